>>> sv/rbsi_pkg.sv
// Shared constants and types for the ray/box slab intersection core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

  localparam int FRAC_BITS_DEF = 14;

  // fixed field widths
  localparam int O_W = 24;   // origin, signed
  localparam int D_W = 16;   // direction, signed
  localparam int H_W = 23;   // half extent, unsigned
  localparam int T_W = 24;   // output distances, signed
  localparam int N_W = 2;    // normal components, signed

  // |numerator| of a slab distance fits in this many bits
  localparam int MAG_W = 24;

  // quotient bits resolved per divider stage
  localparam int DIV_BPS = 4;

  localparam int T_MAX_I = 8388607;
  localparam int T_MIN_I = -8388608;

  localparam logic signed [N_W-1:0] NRM_POS  = 2'sb01;
  localparam logic signed [N_W-1:0] NRM_NEG  = 2'sb11;
  localparam logic signed [N_W-1:0] NRM_ZERO = 2'sb00;

  // per-item control that travels beside the divider pipeline
  typedef struct packed {
    logic       valid;
    logic       miss;   // a zero direction axis with origin outside its slab
    logic [2:0] lim;    // axis sets a finite limit (direction nonzero)
    logic [2:0] dneg;   // direction negative
  } rbsi_side_t;

endpackage

`default_nettype wire

>>> sv/rbsi_prep.sv
// Input stage: slab numerators, their magnitudes and signs, and divisors.
// Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_prep import rbsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic signed [O_W-1:0] org    [3],
  input  logic signed [D_W-1:0] dir    [3],
  input  logic        [H_W-1:0] half   [3],
  output rbsi_side_t            side_o,
  output logic      [MAG_W-1:0] mag_o  [6],
  output logic                  neg_o  [6],
  output logic        [D_W-1:0] den_o  [3]
);

  logic signed [MAG_W:0] o_e   [3];
  logic signed [MAG_W:0] h_e   [3];
  logic signed [MAG_W:0] n_in  [3];
  logic signed [MAG_W:0] n_out [3];
  logic [2:0]            dz;
  logic [2:0]            dpos;
  logic [2:0]            in_slab;

  logic [MAG_W-1:0] mag_nxt [6];
  logic             neg_nxt [6];
  logic [D_W-1:0]   den_nxt [3];
  logic [2:0]       dneg_nxt;
  logic             miss_nxt;

  logic             valid_r;
  logic             miss_r;
  logic [2:0]       lim_r;
  logic [2:0]       dneg_r;
  logic [MAG_W-1:0] mag_r [6];
  logic             neg_r [6];
  logic [D_W-1:0]   den_r [3];

  always_comb begin
    miss_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      o_e[i]      = (MAG_W+1)'(org[i]);
      h_e[i]      = (MAG_W+1)'($signed({1'b0, half[i]}));
      dz[i]       = (dir[i] == '0);
      dneg_nxt[i] = dir[i][D_W-1];
      dpos[i]     = !dz[i] && !dir[i][D_W-1];
      // entry/exit numerators for a positive or a negative direction
      n_in[i]     = dpos[i] ? (-o_e[i] - h_e[i]) : (o_e[i] - h_e[i]);
      n_out[i]    = dpos[i] ? (h_e[i] - o_e[i]) : (o_e[i] + h_e[i]);
      in_slab[i]  = (o_e[i] <= h_e[i]) && (-o_e[i] <= h_e[i]);
      if (dz[i] && !in_slab[i]) begin
        miss_nxt = 1'b1;
      end
      neg_nxt[2*i]   = n_in[i][MAG_W];
      mag_nxt[2*i]   = n_in[i][MAG_W] ? MAG_W'(-n_in[i]) : n_in[i][MAG_W-1:0];
      neg_nxt[2*i+1] = n_out[i][MAG_W];
      mag_nxt[2*i+1] = n_out[i][MAG_W] ? MAG_W'(-n_out[i]) : n_out[i][MAG_W-1:0];
      den_nxt[i]     = dir[i][D_W-1] ? D_W'(-dir[i]) : D_W'(dir[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    miss_r <= miss_nxt;
    lim_r  <= ~dz;
    dneg_r <= dneg_nxt;
    for (int k = 0; k < 6; k++) begin
      mag_r[k] <= mag_nxt[k];
      neg_r[k] <= neg_nxt[k];
    end
    for (int i = 0; i < 3; i++) begin
      den_r[i] <= den_nxt[i];
    end
  end

  assign side_o = '{valid: valid_r, miss: miss_r, lim: lim_r, dneg: dneg_r};
  assign mag_o  = mag_r;
  assign neg_o  = neg_r;
  assign den_o  = den_r;

endmodule

`default_nettype wire

>>> sv/rbsi_div.sv
// Pipelined restoring divider: (mag << FRAC_BITS) / den, truncated, then signed.
// DIV_BPS quotient bits per stage plus one sign stage. Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div import rbsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic [MAG_W-1:0]              mag,
  input  logic                          neg,
  input  logic [D_W-1:0]                den,
  output logic signed [MAG_W+FRAC_BITS:0] quot
);

  localparam int NW = MAG_W + FRAC_BITS;
  localparam int NS = (NW + DIV_BPS - 1) / DIV_BPS;
  localparam int PW = NS * DIV_BPS;

  logic [D_W-1:0] rem_r  [NS];
  logic [PW-1:0]  acc_r  [NS];
  logic [D_W-1:0] den_r  [NS];
  logic           neg_r  [NS];
  logic [D_W-1:0] rem_nxt[NS];
  logic [PW-1:0]  acc_nxt[NS];
  logic [D_W-1:0] den_nxt[NS];
  logic           neg_nxt[NS];
  logic signed [NW:0] quot_r;

  // acc holds the dividend bits still to shift in (top) and quotient bits (bottom)
  always_comb begin
    logic [D_W:0]   r;
    logic [D_W-1:0] rm;
    logic [PW-1:0]  a;
    logic [D_W-1:0] dv;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rm = '0;
        a  = PW'({mag, {FRAC_BITS{1'b0}}});
        dv = den;
        neg_nxt[s] = neg;
      end else begin
        rm = rem_r[s-1];
        a  = acc_r[s-1];
        dv = den_r[s-1];
        neg_nxt[s] = neg_r[s-1];
      end
      for (int b = 0; b < DIV_BPS; b++) begin
        r = {rm, a[PW-1]};
        a = {a[PW-2:0], 1'b0};
        if (r >= {1'b0, dv}) begin
          r    = r - {1'b0, dv};
          a[0] = 1'b1;
        end
        rm = r[D_W-1:0];
      end
      rem_nxt[s] = rm;
      acc_nxt[s] = a;
      den_nxt[s] = dv;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      rem_r[s] <= rem_nxt[s];
      acc_r[s] <= acc_nxt[s];
      den_r[s] <= den_nxt[s];
      neg_r[s] <= neg_nxt[s];
    end
    quot_r <= neg_r[NS-1] ? -$signed({1'b0, acc_r[NS-1][NW-1:0]})
                          :  $signed({1'b0, acc_r[NS-1][NW-1:0]});
  end

  assign quot = quot_r;

endmodule

`default_nettype wire

>>> sv/rbsi_resolve.sv
// Back end: pairwise compares, near/far selection, hit test, saturation, normal.
// Three register stages. Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_resolve import rbsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rbsi_side_t                       side_i,
  input  logic signed [MAG_W+FRAC_BITS:0]  t1 [3],
  input  logic signed [MAG_W+FRAC_BITS:0]  t2 [3],
  output logic                             valid_o,
  output logic                             hit_o,
  output logic signed [T_W-1:0]            t_near_o,
  output logic signed [T_W-1:0]            t_far_o,
  output logic signed [N_W-1:0]            nrm_o [3]
);

  localparam int W = MAG_W + FRAC_BITS + 1;
  localparam logic signed [W-1:0]   SAT_HI = W'(T_MAX_I);
  localparam logic signed [W-1:0]   SAT_LO = W'(T_MIN_I);
  localparam logic signed [T_W-1:0] T_HI   = T_W'(T_MAX_I);
  localparam logic signed [T_W-1:0] T_LO   = T_W'(T_MIN_I);
  localparam int                    M1_I   = -(2 ** FRAC_BITS);
  localparam logic signed [T_W-1:0] T_M1   = T_W'(M1_I);

  // stage A: pairwise compares, an unlimited axis counts as infinite
  logic [2:0]        gt_nxt [3];
  logic [2:0]        lt_nxt [3];
  rbsi_side_t        sa_side_r;
  logic signed [W-1:0] t1_r [3];
  logic signed [W-1:0] t2_r [3];
  logic [2:0]        gt_r [3];
  logic [2:0]        lt_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        gt_nxt[i][j] = (i != j) && side_i.lim[i] && (!side_i.lim[j] || (t1[i] > t1[j]));
        lt_nxt[i][j] = (i != j) && side_i.lim[i] && (!side_i.lim[j] || (t2[i] < t2[j]));
      end
    end
  end

  // stage B: select near/far, entry face
  logic [1:0]          sn0;
  logic [1:0]          sn;
  logic [1:0]          sf0;
  logic [1:0]          sf;
  logic signed [N_W-1:0] nrm_nxt [3];
  rbsi_side_t          sb_side_r;
  logic signed [W-1:0] tn_r;
  logic signed [W-1:0] tf_r;
  logic                tn_inf_r;
  logic                tf_inf_r;
  logic signed [N_W-1:0] nrm_r [3];

  always_comb begin
    sn0 = gt_r[1][0] ? 2'd1 : 2'd0;
    sn  = gt_r[2][sn0] ? 2'd2 : sn0;
    sf0 = lt_r[1][0] ? 2'd1 : 2'd0;
    sf  = lt_r[2][sf0] ? 2'd2 : sf0;
    for (int i = 0; i < 3; i++) begin
      // strictly greater than both others
      if ((gt_r[i] | 3'(1 << i)) == 3'b111) begin
        nrm_nxt[i] = sa_side_r.dneg[i] ? NRM_POS : NRM_NEG;
      end else begin
        nrm_nxt[i] = NRM_ZERO;
      end
    end
  end

  // stage C: hit test and saturation
  logic                miss_c;
  logic signed [T_W-1:0] tn_c;
  logic signed [T_W-1:0] tf_c;
  logic                valid_r;
  logic                hit_r;
  logic signed [T_W-1:0] t_near_r;
  logic signed [T_W-1:0] t_far_r;
  logic signed [N_W-1:0] nrm_out_r [3];

  always_comb begin
    miss_c = sb_side_r.miss
           || (!tn_inf_r && !tf_inf_r && (tn_r > tf_r))
           || (!tf_inf_r && (tf_r < 0));
    if (tn_inf_r || (tn_r < SAT_LO)) begin
      tn_c = T_LO;
    end else if (tn_r > SAT_HI) begin
      tn_c = T_HI;
    end else begin
      tn_c = tn_r[T_W-1:0];
    end
    if (tf_inf_r || (tf_r > SAT_HI)) begin
      tf_c = T_HI;
    end else if (tf_r < SAT_LO) begin
      tf_c = T_LO;
    end else begin
      tf_c = tf_r[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_side_r <= '0;
      sb_side_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      sa_side_r <= side_i;
      sb_side_r <= sa_side_r;
      valid_r   <= sb_side_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t1_r[i]      <= t1[i];
      t2_r[i]      <= t2[i];
      gt_r[i]      <= gt_nxt[i];
      lt_r[i]      <= lt_nxt[i];
      nrm_r[i]     <= nrm_nxt[i];
      nrm_out_r[i] <= miss_c ? NRM_ZERO : nrm_r[i];
    end
    tn_r     <= t1_r[sn];
    tf_r     <= t2_r[sf];
    tn_inf_r <= !sa_side_r.lim[sn];
    tf_inf_r <= !sa_side_r.lim[sf];
    hit_r    <= !miss_c;
    t_near_r <= miss_c ? T_M1 : tn_c;
    t_far_r  <= miss_c ? T_M1 : tf_c;
  end

  assign valid_o  = valid_r;
  assign hit_o    = hit_r;
  assign t_near_o = t_near_r;
  assign t_far_o  = t_far_r;
  assign nrm_o    = nrm_out_r;

endmodule

`default_nettype wire

>>> sv/ray_box_slab_intersect_core.sv
// Ray versus box slab intersection, one ray accepted per clock, busy stays low.
// Between start and out_valid lie the input register, the six pipelined dividers
// (4 quotient bits a stage) and the resolve stages.
// Throughput: one item per cycle; the receiver cannot stall, out_valid is a strobe.
// Reset (rst_n low, synchronous) clears the valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect_core import rbsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [O_W-1:0] in_origin_x,
  input  logic signed [O_W-1:0] in_origin_y,
  input  logic signed [O_W-1:0] in_origin_z,
  input  logic signed [D_W-1:0] in_dir_x,
  input  logic signed [D_W-1:0] in_dir_y,
  input  logic signed [D_W-1:0] in_dir_z,
  input  logic        [H_W-1:0] in_half_x,
  input  logic        [H_W-1:0] in_half_y,
  input  logic        [H_W-1:0] in_half_z,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic signed [T_W-1:0] out_t_near,
  output logic signed [T_W-1:0] out_t_far,
  output logic signed [N_W-1:0] out_normal_x,
  output logic signed [N_W-1:0] out_normal_y,
  output logic signed [N_W-1:0] out_normal_z
);

  localparam int NS  = (MAG_W + FRAC_BITS + DIV_BPS - 1) / DIV_BPS;
  localparam int LAT = NS + 5;
  localparam int QW  = MAG_W + FRAC_BITS + 1;

  logic                  accept;
  logic signed [O_W-1:0] org  [3];
  logic signed [D_W-1:0] dir  [3];
  logic        [H_W-1:0] half [3];
  rbsi_side_t            side_p;
  logic [MAG_W-1:0]      mag  [6];
  logic                  neg  [6];
  logic [D_W-1:0]        den  [3];
  logic signed [QW-1:0]  quot [6];
  logic signed [QW-1:0]  t1   [3];
  logic signed [QW-1:0]  t2   [3];
  rbsi_side_t            side_line_r [NS+1];
  logic signed [N_W-1:0] nrm  [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign org  = '{in_origin_x, in_origin_y, in_origin_z};
  assign dir  = '{in_dir_x, in_dir_y, in_dir_z};
  assign half = '{in_half_x, in_half_y, in_half_z};

  rbsi_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .org    (org),
    .dir    (dir),
    .half   (half),
    .side_o (side_p),
    .mag_o  (mag),
    .neg_o  (neg),
    .den_o  (den)
  );

  for (genvar k = 0; k < 6; k++) begin : g_div
    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk  (clk),
      .mag  (mag[k]),
      .neg  (neg[k]),
      .den  (den[k/2]),
      .quot (quot[k])
    );
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign t1[i] = quot[2*i];
    assign t2[i] = quot[2*i+1];
  end

  // control rides beside the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NS; s++) begin
        side_line_r[s] <= '0;
      end
    end else begin
      side_line_r[0] <= side_p;
      for (int s = 1; s <= NS; s++) begin
        side_line_r[s] <= side_line_r[s-1];
      end
    end
  end

  rbsi_resolve #(.FRAC_BITS(FRAC_BITS)) u_resolve (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_i   (side_line_r[NS]),
    .t1       (t1),
    .t2       (t2),
    .valid_o  (out_valid),
    .hit_o    (out_hit),
    .t_near_o (out_t_near),
    .t_far_o  (out_t_far),
    .nrm_o    (nrm)
  );

  assign out_normal_x = nrm[0];
  assign out_normal_y = nrm[1];
  assign out_normal_z = nrm[2];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("item did not come out after the pipeline latency");

  a_one_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_normal_x != 0, out_normal_y != 0, out_normal_z != 0}) <= 1))
    else $error("more than one entry face reported");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |->
      (out_normal_x == 0 && out_normal_y == 0 && out_normal_z == 0 && out_t_near == out_t_far))
    else $error("miss result not cleared");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_t_near <= out_t_far))
    else $error("hit with near past far");

endmodule

`default_nettype wire

>>> verif/tb_ray_box_slab_intersect_core.sv
// Self-checking testbench for ray_box_slab_intersect_core: directed and random rays,
// predicted by a slab-method model in the bench, compared field by field in order.
// Depends on rbsi_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect_core;
  import rbsi_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 5 + (24 + FRAC + 3) / 4;
  localparam int WATCHDOG = 2000;
  localparam longint BIG_NEG = -(64'sd1 <<< 62);
  localparam longint BIG_POS = (64'sd1 <<< 62);
  localparam int ONE = 1 << FRAC;
  localparam int HMAX = 8388607;

  typedef struct {
    logic signed [O_W-1:0] o[3];
    logic signed [D_W-1:0] d[3];
    logic        [H_W-1:0] h[3];
  } ray_t;

  typedef struct {
    logic                  hit;
    logic signed [T_W-1:0] t_near;
    logic signed [T_W-1:0] t_far;
    logic signed [N_W-1:0] nrm[3];
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [O_W-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [D_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic        [H_W-1:0] in_half_x = '0, in_half_y = '0, in_half_z = '0;
  logic out_valid, out_hit;
  logic signed [T_W-1:0] out_t_near, out_t_far;
  logic signed [N_W-1:0] out_normal_x, out_normal_y, out_normal_z;

  ray_box_slab_intersect_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_half_x(in_half_x), .in_half_y(in_half_y), .in_half_z(in_half_z),
    .out_valid(out_valid), .out_hit(out_hit), .out_t_near(out_t_near),
    .out_t_far(out_t_far), .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ray_t   ray_q[$];
  isect_t hit_expect_q[$];
  int     idle_pct = 29;
  int     errors = 0;
  int     quiet_cycles = 0;

  function automatic void add_ray(ray_t r);
    ray_q = {ray_q, r};
  endfunction

  function automatic longint clamp_t(longint v);
    if (v > T_MAX_I) return T_MAX_I;
    if (v < T_MIN_I) return T_MIN_I;
    return v;
  endfunction

  function automatic isect_t trace_box(ray_t r);
    isect_t res;
    longint o, d, h, t_in[3], t_out[3], tn, tf;
    bit ok;
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      o = longint'(r.o[i]);
      d = longint'(r.d[i]);
      h = longint'(r.h[i]);
      if (d == 0) begin
        t_in[i] = BIG_NEG;
        t_out[i] = BIG_POS;
        if (o > h || -o > h) ok = 1'b0;
      end else if (d > 0) begin
        t_in[i] = ((-o - h) <<< FRAC) / d;
        t_out[i] = ((h - o) <<< FRAC) / d;
      end else begin
        t_in[i] = ((o - h) <<< FRAC) / (-d);
        t_out[i] = ((o + h) <<< FRAC) / (-d);
      end
    end
    tn = t_in[0];
    tf = t_out[0];
    for (int i = 1; i < 3; i++) begin
      if (t_in[i] > tn) tn = t_in[i];
      if (t_out[i] < tf) tf = t_out[i];
    end
    if (ok && (tn > tf || tf < 0)) ok = 1'b0;
    res.hit = ok;
    for (int i = 0; i < 3; i++) res.nrm[i] = NRM_ZERO;
    if (!ok) begin
      res.t_near = T_W'(-(1 <<< FRAC));
      res.t_far = T_W'(-(1 <<< FRAC));
      return res;
    end
    res.t_near = T_W'(clamp_t(tn));
    res.t_far = T_W'(clamp_t(tf));
    for (int i = 0; i < 3; i++)
      if (t_in[i] > t_in[(i + 1) % 3] && t_in[i] > t_in[(i + 2) % 3])
        res.nrm[i] = (r.d[i] > 0) ? NRM_NEG : NRM_POS;
    return res;
  endfunction

  // driver: one item per accepted start
  always @(posedge clk) begin
    ray_t   r;
    isect_t p;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        p = trace_box(ray_q.pop_front());
        hit_expect_q = {hit_expect_q, p};
      end
      if ((start && !busy || !start) && ray_q.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        r = ray_q[0];
        start <= 1'b1;
        in_origin_x <= r.o[0]; in_origin_y <= r.o[1]; in_origin_z <= r.o[2];
        in_dir_x <= r.d[0]; in_dir_y <= r.d[1]; in_dir_z <= r.d[2];
        in_half_x <= r.h[0]; in_half_y <= r.h[1]; in_half_z <= r.h[2];
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    isect_t e;
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid) begin
        if (hit_expect_q.size() == 0) begin
          $error("result with no item pending");
          errors++;
        end else begin
          e = hit_expect_q.pop_front();
          if (out_hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, out_hit); errors++;
          end
          if (out_t_near !== e.t_near) begin
            $error("t_near exp %0d got %0d", e.t_near, out_t_near); errors++;
          end
          if (out_t_far !== e.t_far) begin
            $error("t_far exp %0d got %0d", e.t_far, out_t_far); errors++;
          end
          if (out_normal_x !== e.nrm[0]) begin
            $error("normal_x exp %0d got %0d", e.nrm[0], out_normal_x); errors++;
          end
          if (out_normal_y !== e.nrm[1]) begin
            $error("normal_y exp %0d got %0d", e.nrm[1], out_normal_y); errors++;
          end
          if (out_normal_z !== e.nrm[2]) begin
            $error("normal_z exp %0d got %0d", e.nrm[2], out_normal_z); errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG) begin
      $display("** ray_box_slab_intersect_core: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [D_W-1:0] rand_dir();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return $signed(D_W'($urandom_range(32, 0))) - 16'sd16;
      default: return $signed(D_W'($urandom_range(32768, 0))) - 16'sd16384;
    endcase
  endfunction

  // mostly rays aimed near a box of moderate size, plus full-range noise
  function automatic ray_t rand_ray();
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      r.d[i] = rand_dir();
      if ($urandom_range(3) == 0) begin
        r.o[i] = O_W'($urandom);
        r.h[i] = H_W'($urandom);
      end else begin
        r.h[i] = H_W'($urandom_range(1 << 20));
        r.o[i] = $signed(O_W'($urandom_range(1 << 22))) - 24'sd2097152;
      end
      if ($urandom_range(15) == 0) r.o[i] = O_W'(r.h[i]);
    end
    return r;
  endfunction

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                              int hx, int hy, int hz);
    ray_t r;
    r.o[0] = O_W'(ox); r.o[1] = O_W'(oy); r.o[2] = O_W'(oz);
    r.d[0] = D_W'(dx); r.d[1] = D_W'(dy); r.d[2] = D_W'(dz);
    r.h[0] = H_W'(hx); r.h[1] = H_W'(hy); r.h[2] = H_W'(hz);
    return r;
  endfunction

  task automatic drain();
    int n;
    n = 0;
    while ((ray_q.size() > 0 || hit_expect_q.size() > 0 || start) && n < 200000) begin
      @(posedge clk);
      n++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // axis-aligned hits, both direction signs
    add_ray(mk(-4 * ONE, 0, 0, ONE, 0, 0, ONE, ONE, ONE));
    add_ray(mk(4 * ONE, 0, 0, -ONE, 0, 0, ONE, ONE, ONE));
    add_ray(mk(0, -4 * ONE, 0, 0, ONE, 0, ONE, ONE, ONE));
    add_ray(mk(0, 0, 4 * ONE, 0, 0, -ONE, ONE, ONE, ONE));
    // zero direction, origin outside: miss
    add_ray(mk(2 * ONE, 0, 0, 0, ONE, 0, ONE, ONE, ONE));
    // all direction zero, inside: saturated hit, zero normal
    add_ray(mk(0, 0, 0, 0, 0, 0, ONE, ONE, ONE));
    add_ray(mk(ONE, -ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
    // box behind the ray
    add_ray(mk(4 * ONE, 0, 0, ONE, 0, 0, ONE, ONE, ONE));
    // diagonal tie: zero normal
    add_ray(mk(-2 * ONE, -2 * ONE, 0, 11585, 11585, 0, ONE, ONE, ONE));
    // origin inside, negative near
    add_ray(mk(0, 0, 0, 9459, 9459, 9459, ONE, ONE, ONE));
    // extremes: huge origin, tiny direction, saturation
    add_ray(mk(-8388608, 0, 0, 1, 0, 0, HMAX, HMAX, HMAX));
    add_ray(mk(8388607, 8388607, 8388607, -1, -1, -1, HMAX, HMAX, HMAX));
    add_ray(mk(-8388608, -8388608, -8388608, 16384, 16384, 16384, 0, 0, 0));
    add_ray(mk(0, 0, 0, -16384, 1, -1, 0, 0, 0));
    add_ray(mk(-8388608, 0, 0, -16384, 0, 0, HMAX, 0, 0));
    add_ray(mk(-1, 5, -7, 3, -16384, 16384, HMAX, 1, 0));
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 29 : (phase == 1) ? 70 : 0;
      for (int k = 0; k < 500; k++) add_ray(rand_ray());
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && hit_expect_q.size() == 0) begin
      $display("** ray_box_slab_intersect_core: PASSED **");
    end else begin
      $display("** ray_box_slab_intersect_core: FAILED **");
    end
    $finish;
  end

endmodule
